>>> src/cigar_run_encoder_core_macros.svh
// Assertion macros shared by the run encoder modules.
// Both macros expect signals named clk and rst_n in the calling scope.
`ifndef CIGAR_RUN_ENCODER_CORE_MACROS_SVH
`define CIGAR_RUN_ENCODER_CORE_MACROS_SVH

// Invariant that must hold at every clock edge out of reset.
`define CRE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define CRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cre_pkg.sv
// Package for the CIGAR run encoder: beat types, operation codes, sizes.
// No dependencies; used by cre_run_tracker, cre_result_queue and cigar_run_encoder_core.
`timescale 1ns / 1ps

package cre_pkg;

    // Run counter width inside the block; the result field is 16 bits.
    localparam int RUN_LENGTH_BITS  = 16;
    localparam int RUN_FIELD_BITS   = 16;
    localparam int LENGTH_WIDE_BITS =
        (RUN_LENGTH_BITS > RUN_FIELD_BITS) ? RUN_LENGTH_BITS : RUN_FIELD_BITS;

    // Result queue sizing
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Symbol classes
    localparam logic [1:0] CLASS_BASE    = 2'd0;
    localparam logic [1:0] CLASS_GAP     = 2'd1;
    localparam logic [1:0] CLASS_MISSING = 2'd2;

    typedef enum logic [2:0] {
        OP_MATCH         = 3'd0,
        OP_REF_GAP       = 3'd1,
        OP_QUERY_GAP     = 3'd2,
        OP_REF_SKIPPED   = 3'd3,
        OP_QUERY_SKIPPED = 3'd4
    } run_op_t;

    typedef logic [RUN_LENGTH_BITS-1:0] run_count_t;

    typedef struct packed {
        logic [1:0] ref_class;
        logic [1:0] query_class;
        logic       last_column;
    } column_t;

    typedef struct packed {
        run_op_t                   run_op;
        logic [RUN_FIELD_BITS-1:0] run_length;
        logic                      length_saturated;
        logic                      last_run;
    } run_t;

    // Up to two runs leave the tracker per column: the closed one, then the flush.
    typedef struct packed {
        logic first_valid;
        logic second_valid;
        run_t first;
        run_t second;
    } run_push_t;

    // Low field bits of the run counter, zero-extended when the counter is narrower.
    function automatic logic [RUN_FIELD_BITS-1:0] length_field(input run_count_t len);
        logic [LENGTH_WIDE_BITS-1:0] wide;
        wide = LENGTH_WIDE_BITS'(len);
        return wide[RUN_FIELD_BITS-1:0];
    endfunction

endpackage

>>> src/cre_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
// Payload type is set at instantiation; depends on nothing else.
`timescale 1ns / 1ps

interface cre_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/cre_run_tracker.sv
// Open-run tracker: classifies a column, extends or closes the run, flushes on last.
// Depends on cre_pkg and cigar_run_encoder_core_macros.svh.
`timescale 1ns / 1ps
`include "cigar_run_encoder_core_macros.svh"

module cre_run_tracker
    import cre_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  column_t   col,
    output run_push_t push
);

    run_op_t    open_op_reg,        open_op_next;
    run_count_t open_length_reg,    open_length_next;
    logic       open_saturated_reg, open_saturated_next;
    logic       any_emitted_reg,    any_emitted_next;

    run_op_t    col_op;
    logic       same_op;
    logic       close_run;
    run_op_t    upd_op;
    run_count_t upd_length;
    logic       upd_saturated;

    // Fixed priority: ref gap, ref missing, query gap, query missing, match
    always_comb
    begin
        if (col.ref_class == CLASS_GAP)
            col_op = OP_REF_GAP;
        else if (col.ref_class == CLASS_MISSING)
            col_op = OP_QUERY_SKIPPED;
        else if (col.query_class == CLASS_GAP)
            col_op = OP_QUERY_GAP;
        else if (col.query_class == CLASS_MISSING)
            col_op = OP_REF_SKIPPED;
        else
            col_op = OP_MATCH;
    end

    assign same_op   = (col_op == open_op_reg);
    assign close_run = !same_op && (open_length_reg != '0);

    always_comb
    begin
        if (same_op)
        begin
            upd_op = open_op_reg;
            if (open_length_reg == '1)
            begin
                upd_length    = open_length_reg;
                upd_saturated = 1'b1;
            end
            else
            begin
                upd_length    = open_length_reg + run_count_t'(1);
                upd_saturated = open_saturated_reg;
            end
        end
        else
        begin
            upd_op        = col_op;
            upd_length    = run_count_t'(1);
            upd_saturated = 1'b0;
        end
    end

    // Closed run: query gap becomes ref skipped when nothing was emitted yet
    run_t closed_run;
    run_t flush_run;

    always_comb
    begin
        closed_run.run_op = open_op_reg;
        if (open_op_reg == OP_QUERY_GAP && !any_emitted_reg)
            closed_run.run_op = OP_REF_SKIPPED;
        closed_run.run_length       = length_field(open_length_reg);
        closed_run.length_saturated = open_saturated_reg;
        closed_run.last_run         = 1'b0;

        // flushed run is always last, so a query gap is always relabelled
        flush_run.run_op = upd_op;
        if (upd_op == OP_QUERY_GAP)
            flush_run.run_op = OP_REF_SKIPPED;
        flush_run.run_length       = length_field(upd_length);
        flush_run.length_saturated = upd_saturated;
        flush_run.last_run         = 1'b1;
    end

    always_comb
    begin
        push.first_valid  = 1'b0;
        push.second_valid = 1'b0;
        push.first        = flush_run;
        push.second       = flush_run;
        if (accept)
        begin
            if (close_run)
            begin
                push.first_valid  = 1'b1;
                push.first        = closed_run;
                push.second_valid = col.last_column;
            end
            else
            begin
                push.first_valid = col.last_column;
            end
        end
    end

    always_comb
    begin
        open_op_next        = open_op_reg;
        open_length_next    = open_length_reg;
        open_saturated_next = open_saturated_reg;
        any_emitted_next    = any_emitted_reg;
        if (accept)
        begin
            if (col.last_column)
            begin
                open_op_next        = OP_QUERY_SKIPPED;
                open_length_next    = '0;
                open_saturated_next = 1'b0;
                any_emitted_next    = 1'b0;
            end
            else
            begin
                open_op_next        = upd_op;
                open_length_next    = upd_length;
                open_saturated_next = upd_saturated;
                any_emitted_next    = any_emitted_reg | close_run;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_op_reg        <= OP_QUERY_SKIPPED;
            open_length_reg    <= '0;
            open_saturated_reg <= 1'b0;
            any_emitted_reg    <= 1'b0;
        end
        else
        begin
            open_op_reg        <= open_op_next;
            open_length_reg    <= open_length_next;
            open_saturated_reg <= open_saturated_next;
            any_emitted_reg    <= any_emitted_next;
        end
    end

    `CRE_ASSERT_NEXT(a_last_clears, accept && col.last_column,
        open_length_reg == '0 && !any_emitted_reg, "state not cleared after last column")
    `CRE_ASSERT_ALWAYS(a_empty_run_op, open_length_reg != '0 || open_op_reg == OP_QUERY_SKIPPED,
        "empty open run with unexpected operation")
    `CRE_ASSERT_ALWAYS(a_sat_at_max, !open_saturated_reg || open_length_reg == '1,
        "saturation flag set below maximum length")

endmodule

>>> src/cre_result_queue.sv
// Small shift queue of finished runs; head entry drives the output beat.
// Takes up to two runs per cycle. Depends on cre_pkg and the macro header.
`timescale 1ns / 1ps
`include "cigar_run_encoder_core_macros.svh"

module cre_result_queue
    import cre_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  run_push_t push,
    input  logic      pop,
    output run_t      head,
    output logic      head_valid,
    output logic      room
);

    typedef logic [QUEUE_COUNT_BITS-1:0] qcount_t;

    run_t    entry_reg [QUEUE_DEPTH];
    run_t    entry_next[QUEUE_DEPTH];
    qcount_t count_reg, count_next;
    qcount_t base;

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[0];
    // room for two beats regardless of the output side
    assign room       = (count_reg <= qcount_t'(QUEUE_DEPTH - 2));
    assign base       = count_reg - qcount_t'(pop);

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && i < QUEUE_DEPTH - 1)
                entry_next[i] = entry_reg[i + 1];
            else
                entry_next[i] = entry_reg[i];
            if (push.first_valid && qcount_t'(i) == base)
                entry_next[i] = push.first;
            if (push.second_valid && qcount_t'(i) == base + qcount_t'(1))
                entry_next[i] = push.second;
        end
        count_next = count_reg - qcount_t'(pop)
                   + qcount_t'(push.first_valid) + qcount_t'(push.second_valid);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            entry_reg[i] <= entry_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    `CRE_ASSERT_ALWAYS(a_count_bound, count_reg <= qcount_t'(QUEUE_DEPTH),
        "queue count beyond depth")
    `CRE_ASSERT_ALWAYS(a_push_order, !push.second_valid || push.first_valid,
        "second run pushed without first")
    `CRE_ASSERT_ALWAYS(a_push_room, !(push.first_valid || push.second_valid) || room,
        "run pushed without room")
    `CRE_ASSERT_NEXT(a_single_drain, pop && count_reg == qcount_t'(1) && !push.first_valid,
        !head_valid, "queue not empty after last beat taken")

endmodule

>>> src/cigar_run_encoder_core.sv
// CIGAR run-length encoder, top level: column sink, run source.
// Depends on cre_pkg, cre_stream_if, cre_run_tracker and cre_result_queue.
`timescale 1ns / 1ps

// Usage
//   column (sink): one alignment column per beat, ref_class, query_class and
//     last_column. Taken when valid and ready are both high.
//   run (source): one finished CIGAR run per beat (run_op, run_length,
//     length_saturated, last_run). A column gives zero, one or two runs: the
//     run closed by a change of operation, then on the last column the
//     flushed run, marked last_run.
//   Order: a run enters the result queue registers when the column that caused
//     it is taken and is offered on run from the queue head; the second run of a column follows it.
//   Throughput: one column per cycle while the queue has room. The tracker never
//     stalls; the rate is bounded only by the four-entry result queue, which
//     holds ready low while it has fewer than two free places.
//   Reset: rst_n low clears the open run (query skipped, length zero), the
//     alignment history and the queue; ready is already high during reset, as the queue is empty.
//   Stall: while the receiver holds ready low, columns keep being taken until
//     the queue is near full; nothing is dropped or repeated.
module cigar_run_encoder_core
    import cre_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cre_stream_if.sink    column,
    cre_stream_if.source  run
);

    logic      col_accept;
    logic      queue_room;
    logic      run_pop;
    run_push_t run_push;
    column_t   col_beat;

    assign col_beat     = column.payload;
    assign column.ready = queue_room;
    assign col_accept   = column.valid && queue_room;
    assign run_pop      = run.valid && run.ready;

    cre_run_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (col_accept),
        .col    (col_beat),
        .push   (run_push)
    );

    // head of the queue is the output register
    cre_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (run_push),
        .pop        (run_pop),
        .head       (run.payload),
        .head_valid (run.valid),
        .room       (queue_room)
    );

endmodule
